// ===== hdl/uart_register_file_assert.svh =====
// Assertion macros for the UART register file.
// Used by modules that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef UART_REGISTER_FILE_ASSERT_SVH
`define UART_REGISTER_FILE_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define URF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that cons holds in the cycle after ante
`define URF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/urf_pkg.sv =====
// Shared types, register offsets and bit positions for the UART register file.
// No dependencies.
package urf_pkg;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RX_BYTE = 2'd2,
        CMD_TX_DONE = 2'd3
    } t_cmd;

    localparam logic [2:0] OFS_RBR_DLL = 3'd0;
    localparam logic [2:0] OFS_IER_DLM = 3'd1;
    localparam logic [2:0] OFS_IIR_FCR = 3'd2;
    localparam logic [2:0] OFS_LCR     = 3'd3;
    localparam logic [2:0] OFS_MCR     = 3'd4;
    localparam logic [2:0] OFS_LSR     = 3'd5;
    localparam logic [2:0] OFS_MSR     = 3'd6;
    localparam logic [2:0] OFS_SCR     = 3'd7;

    localparam int LCR_DLAB  = 7;
    localparam int MCR_OUT2  = 3;
    localparam int IER_ERDA  = 0;
    localparam int IER_ETHRE = 1;
    localparam int IER_ELSI  = 2;

    localparam logic [7:0] IIR_RLS  = 8'h06;
    localparam logic [7:0] IIR_RDA  = 8'h04;
    localparam logic [7:0] IIR_THRE = 8'h02;
    localparam logic [7:0] IIR_NONE = 8'h01;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] line_byte;
    } t_req_word;

    typedef struct packed {
        logic       vld;
        t_req_word  word;
    } t_req_stage;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
    } t_rsp_word;

    function automatic logic [7:0] iir_value(
        input logic       oe,
        input logic       dr,
        input logic       busy,
        input logic [3:0] ier
    );
        logic [7:0] v;
        priority if (oe && ier[IER_ELSI]) begin
            v = IIR_RLS;
        end else if (dr && ier[IER_ERDA]) begin
            v = IIR_RDA;
        end else if (!busy && ier[IER_ETHRE]) begin
            v = IIR_THRE;
        end else begin
            v = IIR_NONE;
        end
        return v;
    endfunction

endpackage

// ===== hdl/urf_req_if.sv =====
// Request channel: bus access or line event, valid/ready handshake.
// Depends on nothing.
interface urf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] line_byte;

    modport source (output valid, command, reg_offset, write_data, line_byte, input ready);
    modport sink   (input valid, command, reg_offset, write_data, line_byte, output ready);
endinterface

// ===== hdl/urf_rsp_if.sv =====
// Response channel: read data, transmit byte and interrupt line, valid/ready handshake.
// Depends on nothing.
interface urf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;

    modport source (output valid, read_data, tx_valid, tx_byte, irq, input ready);
    modport sink   (input valid, read_data, tx_valid, tx_byte, irq, output ready);
endinterface

// ===== hdl/urf_in_reg.sv =====
// Input register of the UART register file: captures one request word.
// Depends on urf_pkg and urf_req_if.
module urf_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    urf_req_if.sink            i_req,
    input  logic               i_take,
    output urf_pkg::t_req_stage o_stage
);
    import urf_pkg::*;

    logic      r_vld;
    t_req_word r_word;

    assign i_req.ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_word.command    <= i_req.command;
            r_word.reg_offset <= i_req.reg_offset;
            r_word.write_data <= i_req.write_data;
            r_word.line_byte  <= i_req.line_byte;
        end
    end

    assign o_stage.vld  = r_vld;
    assign o_stage.word = r_word;
endmodule

// ===== hdl/urf_core.sv =====
// Register state, access decode and result register of the UART register file.
// Depends on urf_pkg, urf_rsp_if and uart_register_file_assert.svh.
`include "uart_register_file_assert.svh"

module urf_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  urf_pkg::t_req_stage i_stage,
    output logic               o_take,
    urf_rsp_if.source          o_rsp
);
    import urf_pkg::*;

    logic [7:0] r_dll, n_dll;
    logic [7:0] r_dlm, n_dlm;
    logic [3:0] r_ier, n_ier;
    logic [7:0] r_lcr, n_lcr;
    logic [4:0] r_mcr, n_mcr;
    logic [7:0] r_scr, n_scr;
    logic [7:0] r_rbr, n_rbr;
    logic       r_dr, n_dr;
    logic       r_oe, n_oe;
    logic       r_busy, n_busy;
    logic       r_out_vld;
    t_rsp_word  r_out, n_out;

    logic       fire;
    logic       dlab;
    t_cmd       cmd;
    logic [2:0] ofs;
    logic [7:0] wd;
    logic [7:0] iir_now;
    logic [7:0] iir_next;

    assign o_take  = !r_out_vld || o_rsp.ready;
    assign fire    = i_stage.vld && o_take;
    assign dlab    = r_lcr[LCR_DLAB];
    assign cmd     = t_cmd'(i_stage.word.command);
    assign ofs     = i_stage.word.reg_offset;
    assign wd      = i_stage.word.write_data;
    assign iir_now = iir_value(r_oe, r_dr, r_busy, r_ier);

    always_comb begin
        n_dll  = r_dll;
        n_dlm  = r_dlm;
        n_ier  = r_ier;
        n_lcr  = r_lcr;
        n_mcr  = r_mcr;
        n_scr  = r_scr;
        n_rbr  = r_rbr;
        n_dr   = r_dr;
        n_oe   = r_oe;
        n_busy = r_busy;
        n_out  = '0;
        unique case (cmd)
            CMD_READ: begin
                unique case (ofs)
                    OFS_RBR_DLL: begin
                        if (dlab) begin
                            n_out.read_data = r_dll;
                        end else begin
                            n_out.read_data = r_rbr;
                            n_dr = 1'b0;
                        end
                    end
                    OFS_IER_DLM: n_out.read_data = dlab ? r_dlm : {4'b0, r_ier};
                    OFS_IIR_FCR: n_out.read_data = iir_now;
                    OFS_LCR:     n_out.read_data = r_lcr;
                    OFS_MCR:     n_out.read_data = {3'b0, r_mcr};
                    OFS_LSR: begin
                        n_out.read_data = {1'b0, !r_busy, !r_busy, 3'b0, r_oe, r_dr};
                        n_oe = 1'b0;
                    end
                    OFS_MSR:     n_out.read_data = 8'h00;
                    OFS_SCR:     n_out.read_data = r_scr;
                    default:     n_out.read_data = 8'h00;
                endcase
            end
            CMD_WRITE: begin
                unique case (ofs)
                    OFS_RBR_DLL: begin
                        if (dlab) begin
                            n_dll = wd;
                        end else begin
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = wd;
                            n_busy = 1'b1;
                        end
                    end
                    OFS_IER_DLM: begin
                        if (dlab) begin
                            n_dlm = wd;
                        end else begin
                            n_ier = wd[3:0];
                        end
                    end
                    OFS_LCR:     n_lcr = wd;
                    OFS_MCR:     n_mcr = wd[4:0];
                    OFS_SCR:     n_scr = wd;
                    OFS_IIR_FCR, OFS_LSR, OFS_MSR: begin
                    end
                    default: begin
                    end
                endcase
            end
            CMD_RX_BYTE: begin
                if (r_dr) begin
                    n_oe = 1'b1;
                end
                n_rbr = i_stage.word.line_byte;
                n_dr  = 1'b1;
            end
            CMD_TX_DONE: n_busy = 1'b0;
            default: begin
            end
        endcase
        iir_next  = iir_value(n_oe, n_dr, n_busy, n_ier);
        n_out.irq = !iir_next[0] && n_mcr[MCR_OUT2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dll  <= '0;
            r_dlm  <= '0;
            r_ier  <= '0;
            r_lcr  <= '0;
            r_mcr  <= '0;
            r_scr  <= '0;
            r_rbr  <= '0;
            r_dr   <= 1'b0;
            r_oe   <= 1'b0;
            r_busy <= 1'b0;
        end else if (fire) begin
            r_dll  <= n_dll;
            r_dlm  <= n_dlm;
            r_ier  <= n_ier;
            r_lcr  <= n_lcr;
            r_mcr  <= n_mcr;
            r_scr  <= n_scr;
            r_rbr  <= n_rbr;
            r_dr   <= n_dr;
            r_oe   <= n_oe;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_take) begin
            r_out_vld <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.read_data = r_out.read_data;
    assign o_rsp.tx_valid  = r_out.tx_valid;
    assign o_rsp.tx_byte   = r_out.tx_byte;
    assign o_rsp.irq       = r_out.irq;

    `URF_ASSERT_NEXT(a_thr_sets_busy, fire && cmd == CMD_WRITE && ofs == OFS_RBR_DLL && !dlab, r_busy && r_out.tx_valid, "THR write did not set busy")
    `URF_ASSERT_NEXT(a_rx_sets_ready, fire && cmd == CMD_RX_BYTE, r_dr, "received byte did not set data ready")
    `URF_ASSERT_NEXT(a_rx_overrun, fire && cmd == CMD_RX_BYTE && r_dr, r_oe, "receive on full holding register missed overrun")
    `URF_ASSERT_SAME(a_irq_gated, r_out_vld && r_out.irq, r_mcr[MCR_OUT2], "interrupt raised with OUT2 clear")
endmodule

// ===== hdl/uart_register_file.sv =====
// Top level of the UART register file: input register feeding the register core.
// Depends on urf_pkg, urf_req_if, urf_rsp_if, urf_in_reg and urf_core.
//
// Usage:
//   i_req carries one word per access: a bus read or write at one of eight
//   byte offsets, a byte received from the line, or a transmit-done tick.
//   o_rsp returns one word for every request: read data (zero unless a read),
//   the byte handed to the transmitter on a THR write, and the interrupt line
//   as it stands after that request.
//   The response is valid once its word is in the result register: the input
//   register captures the word, and decode moves it into the result register
//   as soon as that register is free.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the single decode-and-update pass between the two registers;
//   register state updates as each word moves into the result register.
//   When the receiver stalls, the result register holds its word and the
//   input register takes at most one more request before i_req.ready drops.
//   Reset clears all UART registers and flags, leaving the transmitter empty.
module uart_register_file (
    input  logic      i_clk,
    input  logic      i_rst_n,
    urf_req_if.sink   i_req,
    urf_rsp_if.source o_rsp
);
    import urf_pkg::*;

    t_req_stage stage;
    logic       take;

    urf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (take),
        .o_stage (stage)
    );

    urf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (stage),
        .o_take  (take),
        .o_rsp   (o_rsp)
    );
endmodule

// ===== verif/tb_uart_register_file.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for uart_register_file: directed register-map cases plus random traffic.
// Depends on urf_pkg, urf_req_if, urf_rsp_if and the uart_register_file RTL.
module tb_uart_register_file;
    import urf_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 80;

    logic i_clk = 1'b0;
    logic i_rst_n;

    urf_req_if req_if ();
    urf_rsp_if rsp_if ();

    uart_register_file DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    logic [7:0] dll_r        = '0;
    logic [7:0] dlm_r        = '0;
    logic [3:0] ier_r        = '0;
    logic [7:0] lcr_r        = '0;
    logic [4:0] mcr_r        = '0;
    logic [7:0] scr_r        = '0;
    logic [7:0] rbr_r        = '0;
    logic       data_ready_r = 1'b0;
    logic       overrun_r    = 1'b0;
    logic       tx_busy_r    = 1'b0;

    t_rsp_word expected_rsp_q[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_req        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int fail_count      = 0;
    int words_sent      = 0;
    int results_checked = 0;

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic logic [7:0] pending_iir();
        if (overrun_r && ier_r[IER_ELSI]) begin
            return IIR_RLS;
        end else if (data_ready_r && ier_r[IER_ERDA]) begin
            return IIR_RDA;
        end else if (!tx_busy_r && ier_r[IER_ETHRE]) begin
            return IIR_THRE;
        end
        return IIR_NONE;
    endfunction

    function automatic void predict_response(t_req_word w);
        t_rsp_word r;
        logic      dlab;
        r    = '0;
        dlab = lcr_r[LCR_DLAB];
        case (t_cmd'(w.command))
            CMD_READ: begin
                case (w.reg_offset)
                    OFS_RBR_DLL: begin
                        if (dlab) begin
                            r.read_data = dll_r;
                        end else begin
                            r.read_data  = rbr_r;
                            data_ready_r = 1'b0;
                        end
                    end
                    OFS_IER_DLM: r.read_data = dlab ? dlm_r : {4'h0, ier_r};
                    OFS_IIR_FCR: r.read_data = pending_iir();
                    OFS_LCR:     r.read_data = lcr_r;
                    OFS_MCR:     r.read_data = {3'b000, mcr_r};
                    OFS_LSR: begin
                        r.read_data = {1'b0, !tx_busy_r, !tx_busy_r, 3'b000, overrun_r,
                                       data_ready_r};
                        overrun_r   = 1'b0;
                    end
                    OFS_MSR:     r.read_data = 8'h00;
                    default:     r.read_data = scr_r;
                endcase
            end
            CMD_WRITE: begin
                case (w.reg_offset)
                    OFS_RBR_DLL: begin
                        if (dlab) begin
                            dll_r = w.write_data;
                        end else begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = w.write_data;
                            tx_busy_r  = 1'b1;
                        end
                    end
                    OFS_IER_DLM: begin
                        if (dlab) begin
                            dlm_r = w.write_data;
                        end else begin
                            ier_r = w.write_data[3:0];
                        end
                    end
                    OFS_LCR: lcr_r = w.write_data;
                    OFS_MCR: mcr_r = w.write_data[4:0];
                    OFS_SCR: scr_r = w.write_data;
                    default: ;
                endcase
            end
            CMD_RX_BYTE: begin
                if (data_ready_r) begin
                    overrun_r = 1'b1;
                end
                rbr_r        = w.line_byte;
                data_ready_r = 1'b1;
            end
            default: tx_busy_r = 1'b0;
        endcase
        r.irq = (pending_iir() != IIR_NONE) && mcr_r[MCR_OUT2];
        expected_rsp_q.push_back(r);
    endfunction

    function automatic t_req_word mk_word(t_cmd c, logic [2:0] ofs, logic [7:0] wd,
                                          logic [7:0] lb);
        t_req_word w;
        w.command    = c;
        w.reg_offset = ofs;
        w.write_data = wd;
        w.line_byte  = lb;
        return w;
    endfunction

    function automatic t_req_word random_word();
        t_req_word w;
        w.command    = 2'($urandom_range(3));
        w.reg_offset = 3'($urandom_range(7));
        w.write_data = 8'($urandom_range(255));
        w.line_byte  = 8'($urandom_range(255));
        return w;
    endfunction

    // hold valid until the word is taken, then predict its response
    task automatic send_word(t_req_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= w.command;
        req_if.reg_offset <= w.reg_offset;
        req_if.write_data <= w.write_data;
        req_if.line_byte  <= w.line_byte;
        do begin
            @(posedge i_clk);
        end while (req_if.ready !== 1'b1);
        words_sent++;
        predict_response(w);
    endtask

    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        for (int ofs = 0; ofs < 8; ofs++) begin
            send_word(mk_word(CMD_READ, ofs[2:0], 8'h00, 8'h00));
        end
        wait_results_drained();
    endtask

    task automatic test_divisor_latch();
        send_word(mk_word(CMD_WRITE, OFS_LCR, 8'h80, 8'h00));
        send_word(mk_word(CMD_WRITE, OFS_RBR_DLL, 8'hFF, 8'h00));
        send_word(mk_word(CMD_WRITE, OFS_IER_DLM, 8'h00, 8'h00));
        send_word(mk_word(CMD_READ, OFS_RBR_DLL, 8'h00, 8'h00));
        send_word(mk_word(CMD_READ, OFS_IER_DLM, 8'h00, 8'h00));
        send_word(mk_word(CMD_WRITE, OFS_LCR, 8'h00, 8'h00));
        wait_results_drained();
    endtask

    task automatic test_transmit_and_irq();
        send_word(mk_word(CMD_WRITE, OFS_MCR, 8'hFF, 8'h00));
        send_word(mk_word(CMD_WRITE, OFS_IER_DLM, 8'hFF, 8'h00));
        send_word(mk_word(CMD_WRITE, OFS_IIR_FCR, 8'hFF, 8'h00));
        send_word(mk_word(CMD_WRITE, OFS_RBR_DLL, 8'h00, 8'h00));
        send_word(mk_word(CMD_WRITE, OFS_RBR_DLL, 8'hFF, 8'h00));
        send_word(mk_word(CMD_READ, OFS_IIR_FCR, 8'h00, 8'h00));
        send_word(mk_word(CMD_TX_DONE, OFS_SCR, 8'hFF, 8'hFF));
        wait_results_drained();
    endtask

    task automatic test_receive_overrun();
        send_word(mk_word(CMD_RX_BYTE, OFS_RBR_DLL, 8'hFF, 8'h00));
        send_word(mk_word(CMD_RX_BYTE, OFS_SCR, 8'h00, 8'hFF));
        send_word(mk_word(CMD_READ, OFS_IIR_FCR, 8'h00, 8'h00));
        send_word(mk_word(CMD_READ, OFS_LSR, 8'h00, 8'h00));
        send_word(mk_word(CMD_READ, OFS_RBR_DLL, 8'h00, 8'h00));
        wait_results_drained();
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_word(random_word());
        wait_results_drained();
    endtask

    // stall the response side long enough for the input side to back up
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req++;
        repeat (40) send_word(random_word());
        wait_results_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rsp_word seen;
        t_rsp_word want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen = {rsp_if.read_data, rsp_if.tx_valid, rsp_if.tx_byte, rsp_if.irq};
            if (expected_rsp_q.size() == 0) begin
                log_failure($sformatf("response with none pending: rd=%02h txv=%0b txb=%02h irq=%0b",
                                      seen.read_data, seen.tx_valid, seen.tx_byte, seen.irq));
            end else begin
                want = expected_rsp_q.pop_front();
                results_checked++;
                if (seen.read_data !== want.read_data || seen.tx_valid !== want.tx_valid ||
                    seen.tx_byte !== want.tx_byte || seen.irq !== want.irq) begin
                    log_failure($sformatf(
                        "exp rd=%02h txv=%0b txb=%02h irq=%0b got rd=%02h txv=%0b txb=%02h irq=%0b",
                        want.read_data, want.tx_valid, want.tx_byte, want.irq,
                        seen.read_data, seen.tx_valid, seen.tx_byte, seen.irq));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.command    <= CMD_READ;
        req_if.reg_offset <= OFS_RBR_DLL;
        req_if.write_data <= 8'h00;
        req_if.line_byte  <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 36;
        recv_idle_pct = 68;
        test_reset_values();
        test_divisor_latch();
        test_transmit_and_irq();
        test_receive_overrun();
        test_random_traffic(630, 36, 68);
        test_random_traffic(630, 68, 36);
        test_random_traffic(630, 0, 0);
        test_output_backpressure();

        repeat (SETTLE) @(posedge i_clk);
        if (expected_rsp_q.size() != 0) begin
            log_failure($sformatf("%0d responses never arrived", expected_rsp_q.size()));
        end

        $display("Covered reset values, divisor latch, transmit, receive overrun, irq gating,");
        $display("output stall and random traffic: %0d words sent, %0d responses checked",
                 words_sent, results_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/urf_pkg.sv
hdl/urf_req_if.sv
hdl/urf_rsp_if.sv
hdl/urf_in_reg.sv
hdl/urf_core.sv
hdl/uart_register_file.sv
verif/tb_uart_register_file.sv
